// ===== sv/rsce_pkg.sv =====
// ---------------------------------------------------------------------------
// rsce_pkg
// shared types and constants of the Reno subflow window engine
// ---------------------------------------------------------------------------
`default_nettype none
package rsce_pkg;

	localparam int unsigned APB_AW = 4;

	// register indexes
	localparam logic [1:0] REG_SEG_SIZE  = 2'd0;
	localparam logic [1:0] REG_SACK_ON   = 2'd1;
	localparam logic [1:0] REG_INIT_WIN  = 2'd2;
	localparam logic [1:0] REG_INIT_THR  = 2'd3;

	// reset values
	localparam logic [15:0] SEG_SIZE_RST = 16'd1448;
	localparam logic        SACK_ON_RST  = 1'b1;
	localparam logic [31:0] INIT_WIN_RST = 32'd4380;
	localparam logic [31:0] INIT_THR_RST = 32'hFFFF_FFFF;

	// event kinds
	localparam logic [2:0] KIND_SENT    = 3'd0;
	localparam logic [2:0] KIND_ACK     = 3'd1;
	localparam logic [2:0] KIND_DUPACK  = 3'd2;
	localparam logic [2:0] KIND_RACK    = 3'd3;
	localparam logic [2:0] KIND_TIMEOUT = 3'd4;

	// multiplier operand selects
	localparam logic [1:0] MUL_USABLE = 2'd0;
	localparam logic [1:0] MUL_HALF   = 2'd1;
	localparam logic [1:0] MUL_AVOID  = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] una_seq;
		logic [31:0] max_seq;
		logic [31:0] inflight;
		logic        dup_threshold_hit;
		logic        pacer_limited;
		logic        meta_has_data;
		logic        rto_response;
		logic        rto_abort;
	} item_t;

	typedef struct packed {
		logic [31:0] window;
		logic [31:0] threshold;
		logic [31:0] prior_window;
		logic [31:0] window_segments;
		logic [31:0] recover_point;
		logic        recovering;
		logic        send_request;
		logic        retransmit_request;
		logic        timer_restart;
	} result_t;

	typedef struct packed {
		logic       load_item;
		logic       div_start;
		logic       div_keep;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       update;
		logic       load_result;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	function automatic logic seq_ge(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return ~d[31];
	endfunction

endpackage
`default_nettype wire

// ===== sv/rsce_if.sv =====
// ---------------------------------------------------------------------------
// rsce_in_if / rsce_out_if
// valid/ready channels for event requests and window results
// ---------------------------------------------------------------------------
`default_nettype none
interface rsce_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] una_seq;
	logic [31:0] max_seq;
	logic [31:0] inflight;
	logic        dup_threshold_hit;
	logic        pacer_limited;
	logic        meta_has_data;
	logic        rto_response;
	logic        rto_abort;

	modport source (output valid, kind, una_seq, max_seq, inflight, dup_threshold_hit,
		pacer_limited, meta_has_data, rto_response, rto_abort, input ready);
	modport sink (input valid, kind, una_seq, max_seq, inflight, dup_threshold_hit,
		pacer_limited, meta_has_data, rto_response, rto_abort, output ready);
endinterface

interface rsce_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] window;
	logic [31:0] threshold;
	logic [31:0] prior_window;
	logic [31:0] window_segments;
	logic [31:0] recover_point;
	logic        recovering;
	logic        send_request;
	logic        retransmit_request;
	logic        timer_restart;

	modport source (output valid, window, threshold, prior_window, window_segments,
		recover_point, recovering, send_request, retransmit_request, timer_restart,
		input ready);
	modport sink (input valid, window, threshold, prior_window, window_segments,
		recover_point, recovering, send_request, retransmit_request, timer_restart,
		output ready);
endinterface
`default_nettype wire

// ===== sv/rsce_div.sv =====
// ---------------------------------------------------------------------------
// rsce_div
// restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module rsce_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic [31:0]      quotient,
	output logic             done
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic        take;

	// one quotient bit per step
	always_comb begin
		rem_sh  = {rem_q, quo_q[31]};
		rem_sub = rem_sh - {1'b0, divisor};
		take    = rem_sh >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[15:0] : rem_sh[15:0];
			quo_q <= {quo_q[30:0], take};
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== sv/rsce_ctrl.sv =====
// ---------------------------------------------------------------------------
// rsce_ctrl
// sequencer: divide, three multiplies, update, divide, deliver
// ---------------------------------------------------------------------------
`default_nettype none
module rsce_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire rsce_pkg::status_t sts,
	output rsce_pkg::cmd_t        cmd
);
	import rsce_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV_A, ST_MUL_U, ST_MUL_H, ST_MUL_A, ST_UPD, ST_DIV_B, ST_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// commands decoded from the state
	always_comb begin
		cmd             = '0;
		cmd.load_item   = accept;
		cmd.div_start   = accept;
		unique case (state_q)
			ST_IDLE:  ;
			ST_DIV_A: cmd.div_keep = sts.div_done;
			ST_MUL_U: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_USABLE;
			end
			ST_MUL_H: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_HALF;
			end
			ST_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AVOID;
			end
			ST_UPD: begin
				cmd.update    = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV_B: ;
			ST_DONE:  cmd.load_result = !out_valid || out_ready;
			default:  ;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_DIV_A;
				ST_DIV_A: if (sts.div_done) state_q <= ST_MUL_U;
				ST_MUL_U: state_q <= ST_MUL_H;
				ST_MUL_H: state_q <= ST_MUL_A;
				ST_MUL_A: state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_DIV_B;
				ST_DIV_B: if (sts.div_done) state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/rsce_dpath.sv =====
// ---------------------------------------------------------------------------
// rsce_dpath
// window state, shared divider and multiplier, event update and result
// ---------------------------------------------------------------------------
`default_nettype none
module rsce_dpath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rsce_pkg::cmd_t   cmd,
	output rsce_pkg::status_t     sts,
	input  wire rsce_pkg::item_t  item,
	input  wire logic [15:0]      seg_size,
	input  wire logic             sack_on,
	output rsce_pkg::result_t     res
);
	import rsce_pkg::*;

	// engine state
	logic [31:0] cwnd_q, ssthresh_q, avoid_q, rseq_q, peak_q, mark_q;
	logic        inrec_q, limited_q;

	item_t       item_q;
	logic [31:0] quo_q, usable_q, half_q, prior_q;
	logic [47:0] aprod_q;
	logic        snd_q, rtx_q, tmr_q;

	logic [31:0] div_quo;
	logic        div_done;
	logic [31:0] div_dividend;
	logic        seg_nz;
	logic [31:0] segs1, segs_half, avoid_inc, mul_a;
	logic [47:0] mul_p;
	logic [32:0] seg_ext;

	// event update
	logic [31:0] n_cwnd, n_ss, n_avoid, n_rseq, n_peak, n_mark;
	logic        n_inrec, n_lim, n_snd, n_rtx, n_tmr;
	logic        sample, wlim, start_rec, rec_after;
	logic [32:0] infl_seg, cwnd_seg;

	assign seg_nz  = (seg_size != 16'd0);
	assign seg_ext = {17'd0, seg_size};

	// second pass divides the window being written in the update cycle
	assign div_dividend = cmd.update ? n_cwnd : cwnd_q;

	rsce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (seg_size),
		.quotient (div_quo),
		.done     (div_done)
	);
	assign sts.div_done = div_done;

	// shared multiplier operands
	always_comb begin
		segs1     = (quo_q == 32'd0) ? 32'd1 : quo_q;
		segs_half = (segs1 >> 1) < 32'd2 ? 32'd2 : (segs1 >> 1);
		avoid_inc = (avoid_q != 32'hFFFF_FFFF) ? avoid_q + 32'd1 : avoid_q;
		case (cmd.mul_sel)
			MUL_USABLE: mul_a = segs1;
			MUL_HALF:   mul_a = segs_half;
			default:    mul_a = avoid_inc;
		endcase
		mul_p = {16'd0, mul_a} * {32'd0, seg_size};
	end

	// item, quotient and products
	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= item;
		if (cmd.div_keep)
			quo_q <= div_quo;
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MUL_USABLE: usable_q <= mul_p[31:0];
				MUL_HALF:   half_q   <= mul_p[31:0];
				default:    aprod_q  <= mul_p;
			endcase
		end
	end

	always_comb begin
		n_cwnd   = cwnd_q;
		n_ss     = ssthresh_q;
		n_avoid  = avoid_q;
		n_rseq   = rseq_q;
		n_peak   = peak_q;
		n_mark   = mark_q;
		n_inrec  = inrec_q;
		n_lim    = limited_q;
		n_snd    = 1'b0;
		n_rtx    = 1'b0;
		n_tmr    = 1'b0;
		infl_seg = {1'b0, item_q.inflight} + seg_ext;
		cwnd_seg = {1'b0, cwnd_q} + seg_ext;
		sample   = item_q.inflight >= usable_q;
		start_rec = 1'b0;
		rec_after = 1'b0;

		// cwnd-limited test
		wlim = 1'b0;
		if (seg_nz) begin
			if (item_q.pacer_limited)
				wlim = 1'b1;
			else if (item_q.meta_has_data && infl_seg >= {1'b0, usable_q})
				wlim = 1'b1;
			else if (limited_q)
				wlim = 1'b1;
			else if (cwnd_q < ssthresh_q)
				wlim = {1'b0, usable_q} < {peak_q, 1'b0};
		end

		case (item_q.kind)
			KIND_SENT: begin
				if (seg_nz && (mark_q == 32'd0 || seq_ge(item_q.una_seq, mark_q) || sample ||
						(!limited_q && item_q.inflight > peak_q))) begin
					n_lim  = sample;
					n_peak = item_q.inflight;
					n_mark = item_q.max_seq;
				end
			end
			KIND_ACK: begin
				if (sack_on && inrec_q) begin
					if (seq_ge(item_q.una_seq, rseq_q)) begin
						n_cwnd  = ssthresh_q;
						n_inrec = 1'b0;
					end
				end else begin
					if (wlim) begin
						if (cwnd_q < ssthresh_q) begin
							n_cwnd = cwnd_seg[32] ? 32'hFFFF_FFFF : cwnd_seg[31:0];
						end else if (seg_nz) begin
							n_avoid = avoid_inc;
							if (aprod_q >= {16'd0, cwnd_q}) begin
								if (!cwnd_seg[32])
									n_cwnd = cwnd_seg[31:0];
								n_avoid = 32'd0;
							end
						end
					end
					n_snd = 1'b1;
				end
			end
			KIND_DUPACK: begin
				start_rec = item_q.dup_threshold_hit && sack_on && !inrec_q &&
					(rseq_q == 32'd0 || seq_ge(item_q.una_seq, rseq_q));
				rec_after = inrec_q || start_rec;
				n_rtx     = start_rec;
				n_tmr     = item_q.dup_threshold_hit && rec_after;
				n_snd     = !rec_after;
			end
			KIND_RACK: begin
				if (sack_on) begin
					start_rec = !inrec_q;
					n_rtx     = 1'b1;
					n_tmr     = 1'b1;
				end
			end
			KIND_TIMEOUT: begin
				if (!item_q.rto_abort) begin
					if (item_q.rto_response && seg_nz) begin
						n_ss    = half_q;
						n_avoid = 32'd0;
					end
					n_cwnd = {16'd0, seg_size};
					n_snd  = 1'b1;
				end
			end
			default: ;
		endcase

		// recovery entry: halve threshold, window from inflight
		if (start_rec) begin
			n_rseq  = item_q.max_seq;
			n_inrec = 1'b1;
			if (seg_nz) begin
				n_ss    = half_q;
				n_avoid = 32'd0;
			end
			n_cwnd = infl_seg[32] ? 32'hFFFF_FFFF : infl_seg[31:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cwnd_q     <= INIT_WIN_RST;
			ssthresh_q <= INIT_THR_RST;
			avoid_q    <= '0;
			rseq_q     <= '0;
			inrec_q    <= 1'b0;
			limited_q  <= 1'b0;
			peak_q     <= '0;
			mark_q     <= '0;
		end else if (cmd.update) begin
			cwnd_q     <= n_cwnd;
			ssthresh_q <= n_ss;
			avoid_q    <= n_avoid;
			rseq_q     <= n_rseq;
			inrec_q    <= n_inrec;
			limited_q  <= n_lim;
			peak_q     <= n_peak;
			mark_q     <= n_mark;
		end
	end

	// per-event flags and prior window
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			prior_q <= cwnd_q;
			snd_q   <= n_snd;
			rtx_q   <= n_rtx;
			tmr_q   <= n_tmr;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res.window             <= cwnd_q;
			res.threshold          <= ssthresh_q;
			res.prior_window       <= prior_q;
			res.window_segments    <= seg_nz ? div_quo : 32'd0;
			res.recover_point      <= rseq_q;
			res.recovering         <= inrec_q;
			res.send_request       <= snd_q;
			res.retransmit_request <= rtx_q;
			res.timer_restart      <= tmr_q;
		end
	end
endmodule
`default_nettype wire

// ===== sv/reno_subflow_cwnd_engine.sv =====
// ---------------------------------------------------------------------------
// reno_subflow_cwnd_engine
// Reno congestion window engine for one subflow
// ---------------------------------------------------------------------------
// Takes one event request (data sent, new ack, duplicate ack, rack loss,
// timeout) and returns one result with the new window, threshold, recovery
// state and request flags. One event is processed at a time: a pass of the
// bit-serial divider (cwnd / seg_size before the update), a step to pick up
// its quotient, three products on the shared multiplier, the update, a
// second divider pass (cwnd / seg_size after the update) and the load of the
// result register, which waits while an earlier result is unaccepted. The
// next request is taken as soon as the result is loaded, even while it
// still waits on the output. Registers sit on an APB port at 4*index.
`default_nettype none
module reno_subflow_cwnd_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rsce_pkg::APB_AW-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	rsce_in_if.sink                         in_ch,
	rsce_out_if.source                      out_ch
);
	import rsce_pkg::*;

	logic [15:0] seg_size_q;
	logic        sack_on_q;
	logic [31:0] init_win_q, init_thr_q;
	logic [1:0]  reg_idx;
	cmd_t        cmd;
	status_t     sts;
	item_t       item;
	result_t     res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_size_q <= SEG_SIZE_RST;
			sack_on_q  <= SACK_ON_RST;
			init_win_q <= INIT_WIN_RST;
			init_thr_q <= INIT_THR_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_SEG_SIZE: seg_size_q <= pwdata[15:0];
				REG_SACK_ON:  sack_on_q  <= pwdata[0];
				REG_INIT_WIN: init_win_q <= pwdata;
				REG_INIT_THR: init_thr_q <= pwdata;
				default:      ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (reg_idx)
			REG_SEG_SIZE: prdata = {16'd0, seg_size_q};
			REG_SACK_ON:  prdata = {31'd0, sack_on_q};
			REG_INIT_WIN: prdata = init_win_q;
			REG_INIT_THR: prdata = init_thr_q;
			default:      prdata = '0;
		endcase
	end

	// request payload
	assign item.kind              = in_ch.kind;
	assign item.una_seq           = in_ch.una_seq;
	assign item.max_seq           = in_ch.max_seq;
	assign item.inflight          = in_ch.inflight;
	assign item.dup_threshold_hit = in_ch.dup_threshold_hit;
	assign item.pacer_limited     = in_ch.pacer_limited;
	assign item.meta_has_data     = in_ch.meta_has_data;
	assign item.rto_response      = in_ch.rto_response;
	assign item.rto_abort         = in_ch.rto_abort;

	rsce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rsce_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.seg_size (seg_size_q),
		.sack_on  (sack_on_q),
		.res      (res)
	);

	// result payload
	assign out_ch.window             = res.window;
	assign out_ch.threshold          = res.threshold;
	assign out_ch.prior_window       = res.prior_window;
	assign out_ch.window_segments    = res.window_segments;
	assign out_ch.recover_point      = res.recover_point;
	assign out_ch.recovering         = res.recovering;
	assign out_ch.send_request       = res.send_request;
	assign out_ch.retransmit_request = res.retransmit_request;
	assign out_ch.timer_restart      = res.timer_restart;
endmodule
`default_nettype wire
